// File: rtl/mtx_pkg.sv
package mtx_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 6;
  localparam int PROD_W = 64;

  typedef enum logic [2:0] {
    OP_WR_CUR    = 3'd0,
    OP_WR_OPD    = 3'd1,
    OP_CONCAT    = 3'd2,
    OP_TRANSFORM = 3'd3,
    OP_READ      = 3'd4,
    OP_TRANSPOSE = 3'd5
  } op_t;

  // Tag that travels with one product term through the datapath.
  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [1:0]       k;
    logic             first;
    logic             last;
    logic             fin;
    logic [IDX_W-1:0] dest;
  } tag_t;

  // One finished element leaving the datapath.
  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic                     fin;
    logic [IDX_W-1:0]         dest;
    logic signed [DATA_W-1:0] data;
    logic                     sat;
  } res_t;

endpackage

// File: rtl/mtx_mem.sv
module mtx_mem #(
  parameter int AW        = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic signed [mtx_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]                    raddr,
  output logic signed [mtx_pkg::DATA_W-1:0] rdata
);
  import mtx_pkg::*;

  localparam int DEPTH = 2 ** AW;
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]         vld;
  logic signed [DATA_W-1:0] data_q;
  logic                     vld_q;
  logic [IDX_W-1:0]         idx_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    data_q <= mem[raddr];
    vld_q  <= vld[raddr];
    idx_q  <= raddr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // An entry never written reads as the identity matrix element.
  always_comb begin
    if (vld_q) begin
      rdata = data_q;
    end else if (idx_q[1:0] == idx_q[3:2]) begin
      rdata = ONE;
    end else begin
      rdata = '0;
    end
  end

endmodule

// File: rtl/mtx_seq.sv
module mtx_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  mtx_pkg::op_t                 opcode,
  input  logic [mtx_pkg::IDX_W-1:0]    elem_index,
  input  logic                         bank,
  output logic [mtx_pkg::IDX_W:0]      cur_raddr,
  output logic [mtx_pkg::IDX_W-1:0]    opd_raddr,
  output mtx_pkg::tag_t                issue,
  output logic                         run
);
  import mtx_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state, state_next;
  op_t              op;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_last;
  logic             multi;

  assign multi = (opcode == OP_CONCAT) || (opcode == OP_TRANSFORM) ||
                 (opcode == OP_READ) || (opcode == OP_TRANSPOSE);

  always_comb begin
    case (op)
      OP_CONCAT:    cnt_last = CNT_W'(63);
      OP_TRANSFORM: cnt_last = CNT_W'(11);
      OP_TRANSPOSE: cnt_last = CNT_W'(15);
      default:      cnt_last = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && multi) state_next = ST_RUN;
      ST_RUN:  if (cnt == cnt_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
    if (accept) begin
      op  <= opcode;
      idx <= elem_index;
    end
  end

  assign run = (state == ST_RUN);

  always_comb begin
    issue       = '0;
    issue.valid = run;
    issue.op    = op;
    issue.k     = cnt[1:0];
    issue.fin   = (cnt == cnt_last);
    opd_raddr   = {cnt[1:0], cnt[3:2]};
    case (op)
      OP_CONCAT: begin
        issue.first = (cnt[1:0] == 2'd0);
        issue.last  = (cnt[1:0] == 2'd3);
        issue.dest  = {cnt[5:4], cnt[3:2]};
        cur_raddr   = {bank, cnt[5:4], cnt[1:0]};
      end
      OP_TRANSFORM: begin
        issue.first = (cnt[1:0] == 2'd0);
        issue.last  = (cnt[1:0] == 2'd3);
        issue.dest  = {2'd0, cnt[3:2]};
        cur_raddr   = {bank, cnt[1:0], cnt[3:2]};
      end
      OP_TRANSPOSE: begin
        issue.first = 1'b1;
        issue.last  = 1'b1;
        issue.dest  = cnt[3:0];
        cur_raddr   = {bank, cnt[1:0], cnt[3:2]};
      end
      default: begin
        issue.first = 1'b1;
        issue.last  = 1'b1;
        issue.dest  = idx;
        cur_raddr   = {bank, idx};
      end
    endcase
  end

endmodule

// File: rtl/mtx_mac.sv
module mtx_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mtx_pkg::tag_t                     issue,
  input  logic signed [mtx_pkg::DATA_W-1:0] cur_rd,
  input  logic signed [mtx_pkg::DATA_W-1:0] opd_rd,
  input  logic signed [mtx_pkg::DATA_W-1:0] vx,
  input  logic signed [mtx_pkg::DATA_W-1:0] vy,
  input  logic signed [mtx_pkg::DATA_W-1:0] vz,
  output mtx_pkg::res_t                     res,
  output logic                              pipe_busy
);
  import mtx_pkg::*;

  localparam logic signed [DATA_W-1:0] ONE   = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] MAX_V = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] MIN_V = -PROD_W'(64'sd2147483648);

  tag_t                     tag1, tag2;
  res_t                     res_next;
  logic signed [DATA_W-1:0] a, b, data2;
  logic signed [PROD_W-1:0] prod, term, acc, sum;
  logic                     is_mac, hi, lo;

  always_comb begin
    case (tag1.k)
      2'd0:    a = vx;
      2'd1:    a = vy;
      2'd2:    a = vz;
      default: a = ONE;
    endcase
    b = cur_rd;
    if (tag1.op == OP_CONCAT) begin
      a = cur_rd;
      b = opd_rd;
    end
  end

  // Arithmetic shift of the exact product floors toward negative infinity.
  assign term   = prod >>> FRAC_BITS;
  assign sum    = (tag2.first ? '0 : acc) + term;
  assign is_mac = (tag2.op == OP_CONCAT) || (tag2.op == OP_TRANSFORM);
  assign hi     = sum > MAX_V;
  assign lo     = sum < MIN_V;

  always_comb begin
    res_next       = '0;
    res_next.valid = tag2.valid && tag2.last;
    res_next.op    = tag2.op;
    res_next.fin   = tag2.fin;
    res_next.dest  = tag2.dest;
    res_next.sat   = is_mac && (hi || lo);
    if (!is_mac) begin
      res_next.data = data2;
    end else if (hi) begin
      res_next.data = MAX_V[DATA_W-1:0];
    end else if (lo) begin
      res_next.data = MIN_V[DATA_W-1:0];
    end else begin
      res_next.data = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      res  <= '0;
    end else begin
      tag1 <= issue;
      tag2 <= tag1;
      res  <= res_next;
    end
    prod  <= PROD_W'(a) * PROD_W'(b);
    data2 <= cur_rd;
    if (tag2.valid) begin
      acc <= sum;
    end
  end

  assign pipe_busy = tag1.valid || tag2.valid || res.valid;

endmodule

// File: rtl/matrix4_transform_engine.sv
// Channel   Ports                                          Handshake
// request   opcode elem_index elem_value vec_x vec_y vec_z start, busy
// result    out_x out_y out_z read_value saturated        done (one-cycle strobe)
//
// Element writes and unused opcodes raise done in the cycle after they are taken.
// Reads, transposes, transforms and concatenations run through the single
// multiply-accumulate unit, which takes one term per cycle from the matrix
// memories behind a three-stage pipeline.
// Reset is synchronous and active high; both matrices read as identity after it.
// The receiver cannot stall: each result is valid with done and held only until the next request is taken.
module matrix4_transform_engine #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [3:0]         elem_index,
  input  logic signed [31:0] elem_value,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  output logic               done,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] read_value,
  output logic               saturated
);
  import mtx_pkg::*;

  // The current matrix lives in two banks of a 32-entry memory. Concatenation
  // and transpose read the active bank, write every element of the other bank
  // and then flip, so no partial result ever overwrites an element still needed.
  logic                     accept, run, pipe_busy, bank;
  op_t                      op_in;
  tag_t                     issue;
  res_t                     res;
  logic [IDX_W:0]           cur_raddr, cur_waddr;
  logic [IDX_W-1:0]         opd_raddr;
  logic signed [DATA_W-1:0] cur_rd, opd_rd, cur_wdata;
  logic                     cur_we, opd_we, res_wb;
  logic signed [DATA_W-1:0] vx, vy, vz;

  assign op_in  = op_t'(opcode);
  assign busy   = run || pipe_busy;
  assign accept = start && !busy;

  // Element writes land at the request; pipeline write-backs go to the idle bank.
  assign res_wb    = res.valid && ((res.op == OP_CONCAT) || (res.op == OP_TRANSPOSE));
  assign cur_we    = (accept && (op_in == OP_WR_CUR)) || res_wb;
  assign cur_waddr = accept ? {bank, elem_index} : {!bank, res.dest};
  assign cur_wdata = accept ? elem_value : res.data;
  assign opd_we    = accept && (op_in == OP_WR_OPD);

  mtx_mem #(.AW(IDX_W + 1), .FRAC_BITS(FRAC_BITS)) u_cur (
    .clk(clk), .rst(rst), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_raddr), .rdata(cur_rd)
  );

  mtx_mem #(.AW(IDX_W), .FRAC_BITS(FRAC_BITS)) u_opd (
    .clk(clk), .rst(rst), .we(opd_we), .waddr(elem_index), .wdata(elem_value),
    .raddr(opd_raddr), .rdata(opd_rd)
  );

  mtx_seq u_seq (
    .clk(clk), .rst(rst), .accept(accept), .opcode(op_in), .elem_index(elem_index),
    .bank(bank), .cur_raddr(cur_raddr), .opd_raddr(opd_raddr), .issue(issue),
    .run(run)
  );

  mtx_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .rst(rst), .issue(issue), .cur_rd(cur_rd), .opd_rd(opd_rd),
    .vx(vx), .vy(vy), .vz(vz), .res(res), .pipe_busy(pipe_busy)
  );

  // Result fields are cleared when a request is taken and filled as elements
  // come out of the datapath; done follows the last element, or the request itself if it has none.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      bank <= 1'b0;
    end else begin
      done <= (accept && !((op_in == OP_CONCAT) || (op_in == OP_TRANSFORM) ||
                           (op_in == OP_READ) || (op_in == OP_TRANSPOSE))) ||
              (res.valid && res.fin);
      if (res_wb && res.fin) begin
        bank <= !bank;
      end
    end
    if (accept) begin
      vx         <= vec_x;
      vy         <= vec_y;
      vz         <= vec_z;
      out_x      <= '0;
      out_y      <= '0;
      out_z      <= '0;
      read_value <= '0;
      saturated  <= 1'b0;
    end else if (res.valid) begin
      if (res.sat) begin
        saturated <= 1'b1;
      end
      if (res.op == OP_READ) begin
        read_value <= res.data;
      end
      if (res.op == OP_TRANSFORM) begin
        case (res.dest[1:0])
          2'd0:    out_x <= res.data;
          2'd1:    out_y <= res.data;
          default: out_z <= res.data;
        endcase
      end
    end
  end

  // The datapath has drained by the time a result is shown.
  assert property (@(posedge clk) disable iff (rst) done |-> !pipe_busy && !run)
    else $error("result shown while datapath still active");

  // A pipeline write-back never collides with an element write from a request.
  assert property (@(posedge clk) disable iff (rst) accept |-> !res.valid)
    else $error("request taken while results still in flight");

  // A concatenation or transform keeps the engine busy in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept && ((op_in == OP_CONCAT) || (op_in == OP_TRANSFORM)) |=> busy && !done)
    else $error("multi-cycle request finished too early");

endmodule

// File: sim/matrix4_transform_engine_test.sv
module matrix4_transform_engine_test;
  import mtx_pkg::*;

  // One request as the driver presents it.
  typedef struct {
    logic [2:0]         opc;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } request_t;

  // One expected result, field by field.
  typedef struct {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] rd;
    logic               sat;
  } outcome_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         opcode = '0;
  logic [3:0]         elem_index = '0;
  logic signed [31:0] elem_value = '0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic               done;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] read_value;
  logic               saturated;

  // Requests waiting for the driver, and results waiting for the monitor.
  request_t pending_requests[$];
  outcome_t expected_outcomes[$];

  // The testbench's own copy of the two matrices.
  logic signed [31:0] cur_mtx[16];
  logic signed [31:0] opd_mtx[16];

  int  idle_pct = 0;
  int  error_count = 0;
  int  accepted_count = 0;
  int  result_count = 0;
  int  quiet_cycles = 0;
  bit  stimulus_done = 1'b0;

  // The busy value seen at the last rising edge decides acceptance.
  logic busy_at_edge = 1'b1;

  always #10 clk = ~clk;

  matrix4_transform_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .elem_index(elem_index), .elem_value(elem_value), .vec_x(vec_x), .vec_y(vec_y),
    .vec_z(vec_z), .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .read_value(read_value), .saturated(saturated)
  );

  // A fixed-point product floored to 16 fraction bits. The arithmetic shift of
  // a signed 64-bit value already rounds toward negative infinity.
  function automatic logic signed [65:0] floor_product(logic signed [31:0] a,
                                                       logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 66'(p >>> 16);
  endfunction

  // Clamps a wide sum to the 32-bit range and raises the flag when it had to.
  function automatic logic signed [31:0] clamp_sum(logic signed [65:0] s, ref logic sat);
    if (s > 66'sh7fffffff) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -66'sh80000000) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // Applies one request to the local matrices and returns the result it gives.
  function automatic outcome_t apply_request(request_t rq);
    outcome_t           o;
    logic signed [31:0] prod_mtx[16];
    logic signed [31:0] t;
    logic signed [65:0] acc;
    logic [31:0]        pt[3];
    o = '{ox: 0, oy: 0, oz: 0, rd: 0, sat: 1'b0};
    pt[0] = rq.x;
    pt[1] = rq.y;
    pt[2] = rq.z;
    case (rq.opc)
      OP_WR_CUR: cur_mtx[rq.idx] = rq.val;
      OP_WR_OPD: opd_mtx[rq.idx] = rq.val;
      OP_CONCAT: begin
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
              acc += floor_product(cur_mtx[r*4+k], opd_mtx[k*4+c]);
            prod_mtx[r*4+c] = clamp_sum(acc, o.sat);
          end
        cur_mtx = prod_mtx;
      end
      OP_TRANSFORM: begin
        for (int c = 0; c < 3; c++) begin
          // The homogeneous coordinate contributes the bottom row unscaled.
          acc = 66'(cur_mtx[12+c]);
          for (int k = 0; k < 3; k++)
            acc += floor_product(pt[k], cur_mtx[k*4+c]);
          t = clamp_sum(acc, o.sat);
          if (c == 0) o.ox = t;
          else if (c == 1) o.oy = t;
          else o.oz = t;
        end
      end
      OP_READ: o.rd = cur_mtx[rq.idx];
      OP_TRANSPOSE: begin
        for (int r = 0; r < 4; r++)
          for (int c = r + 1; c < 4; c++) begin
            t = cur_mtx[r*4+c];
            cur_mtx[r*4+c] = cur_mtx[c*4+r];
            cur_mtx[c*4+r] = t;
          end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("MISMATCH result %0d %s: got %0d expected %0d", result_count, what, got, want);
    error_count++;
  endtask

  // Random values lean on the extremes and on small values near one, so that
  // both saturation and ordinary arithmetic are exercised.
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 4 * 65536)) - 2 * 65536;
      3: return $signed($urandom_range(0, 65536 * 300)) - 65536 * 150;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t make_request(logic [2:0] opc, logic [3:0] idx,
                                            logic signed [31:0] val);
    request_t rq;
    rq.opc = opc;
    rq.idx = idx;
    rq.val = val;
    rq.x = rand_value();
    rq.y = rand_value();
    rq.z = rand_value();
    return rq;
  endfunction

  // Driver: requests change at the falling edge. The start line only drops
  // when there is no request left or the sender chooses to idle, so it is
  // never lowered and raised in the same step.
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        void'(pending_requests.pop_front());
      end
      if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        opcode <= pending_requests[0].opc;
        elem_index <= pending_requests[0].idx;
        elem_value <= pending_requests[0].val;
        vec_x <= pending_requests[0].x;
        vec_y <= pending_requests[0].y;
        vec_z <= pending_requests[0].z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts at acceptance and checks every done strobe.
  always @(posedge clk) begin
    outcome_t exp_o;
    busy_at_edge <= busy;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (start && !busy) begin
        expected_outcomes.push_back(apply_request(pending_requests[0]));
        accepted_count++;
      end
      if (done) begin
        result_count++;
        if (expected_outcomes.size() == 0) begin
          $display("MISMATCH unexpected result %0d", result_count);
          error_count++;
        end else begin
          exp_o = expected_outcomes.pop_front();
          if (out_x !== exp_o.ox) report_mismatch("out_x", out_x, exp_o.ox);
          if (out_y !== exp_o.oy) report_mismatch("out_y", out_y, exp_o.oy);
          if (out_z !== exp_o.oz) report_mismatch("out_z", out_z, exp_o.oz);
          if (read_value !== exp_o.rd) report_mismatch("read_value", read_value, exp_o.rd);
          if (saturated !== exp_o.sat)
            report_mismatch("saturated", 32'(saturated), 32'(exp_o.sat));
        end
      end
      // The watchdog only runs while something is still outstanding.
      if ((start && !busy) || done || (stimulus_done && expected_outcomes.size() == 0))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Queues a random mix in which current-matrix writes are most common and matrix changes are
  // frequent enough that every opcode meets varied matrix contents.
  task automatic queue_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25)
        pending_requests.push_back(make_request(OP_WR_CUR, 4'($urandom), rand_value()));
      else if (pick < 45)
        pending_requests.push_back(make_request(OP_WR_OPD, 4'($urandom), rand_value()));
      else if (pick < 55)
        pending_requests.push_back(make_request(OP_CONCAT, 4'($urandom), $urandom));
      else if (pick < 75)
        pending_requests.push_back(make_request(OP_TRANSFORM, 4'($urandom), $urandom));
      else if (pick < 88)
        pending_requests.push_back(make_request(OP_READ, 4'($urandom), $urandom));
      else if (pick < 95)
        pending_requests.push_back(make_request(OP_TRANSPOSE, 4'($urandom), $urandom));
      else
        pending_requests.push_back(make_request(3'($urandom_range(6, 7)), 4'($urandom),
                                                $urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
  endtask

  initial begin
    request_t rq;
    for (int i = 0; i < 16; i++) begin
      cur_mtx[i] = (i % 5 == 0) ? ONE_Q16 : 0;
      opd_mtx[i] = (i % 5 == 0) ? ONE_Q16 : 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reads after reset, a transform through identity, extreme
    // writes, a saturating concatenation and transform, a transpose, and the
    // unused opcodes.
    pending_requests.push_back(make_request(OP_READ, 4'd0, 0));
    pending_requests.push_back(make_request(OP_READ, 4'd15, 0));
    rq = make_request(OP_TRANSFORM, 4'd0, 0);
    rq.x = 32'sh7fffffff;
    rq.y = 32'sh80000000;
    rq.z = -1;
    pending_requests.push_back(rq);
    pending_requests.push_back(make_request(OP_WR_CUR, 4'd1, 32'sh7fffffff));
    pending_requests.push_back(make_request(OP_WR_CUR, 4'd14, 32'sh80000000));
    pending_requests.push_back(make_request(OP_WR_CUR, 4'd0, 32'sh7fffffff));
    pending_requests.push_back(make_request(OP_WR_OPD, 4'd0, 32'sh7fffffff));
    pending_requests.push_back(make_request(OP_WR_OPD, 4'd15, 32'sh80000000));
    pending_requests.push_back(make_request(OP_READ, 4'd1, 0));
    pending_requests.push_back(make_request(OP_TRANSPOSE, 4'd0, 0));
    pending_requests.push_back(make_request(OP_READ, 4'd4, 0));
    pending_requests.push_back(make_request(OP_READ, 4'd1, 0));
    rq = make_request(OP_TRANSFORM, 4'd0, 0);
    rq.x = 32'sh7fffffff;
    rq.y = 32'sh7fffffff;
    rq.z = 32'sh80000000;
    pending_requests.push_back(rq);
    pending_requests.push_back(make_request(OP_CONCAT, 4'd0, 0));
    pending_requests.push_back(make_request(OP_READ, 4'd0, 0));
    pending_requests.push_back(make_request(3'd6, 4'd3, -1));
    pending_requests.push_back(make_request(3'd7, 4'd15, 32'sh55555555));
    pending_requests.push_back(make_request(OP_WR_CUR, 4'd10, 32'sh2aaaaaaa));
    pending_requests.push_back(make_request(OP_READ, 4'd10, 0));
    wait_drained();

    // Random part across the idling phases: none, sender mostly idle, a mix, none again.
    idle_pct = 0;
    queue_random(350);
    wait_drained();
    idle_pct = 84;
    queue_random(250);
    wait_drained();
    idle_pct = 10;
    queue_random(250);
    wait_drained();
    idle_pct = 0;
    queue_random(200);
    wait_drained();
    stimulus_done = 1'b1;
    repeat (100) @(posedge clk);

    $display("covered %0d requests of every opcode with %0d results checked",
             accepted_count, result_count);
    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
